// ===== hdl/ple_pkg.sv =====
package ple_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int POS_W   = 6;
    localparam int CNT_W   = 6;
    localparam int DATA_W  = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic                     ins;   // shift up from pos, load value at pos
        logic                     del;   // shift down from pos
        logic                     tap;   // capture entry at pos for read-out
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } t_cell_ctl;

endpackage

// ===== hdl/ple_cell.sv =====
module ple_cell (
    input  logic                              i_clk,
    input  logic [ple_pkg::IDX_W-1:0]         i_idx,
    input  ple_pkg::t_cell_ctl                i_ctl,
    input  logic signed [ple_pkg::DATA_W-1:0] i_lower,
    input  logic signed [ple_pkg::DATA_W-1:0] i_upper,
    output logic signed [ple_pkg::DATA_W-1:0] o_val,
    output logic signed [ple_pkg::DATA_W-1:0] o_tap
);

    logic signed [ple_pkg::DATA_W-1:0] r_val;
    logic signed [ple_pkg::DATA_W-1:0] n_val;
    logic signed [ple_pkg::DATA_W-1:0] r_tap;
    logic [ple_pkg::POS_W-1:0]         w_idx;
    logic                              w_above;
    logic                              w_at;

    assign w_idx   = ple_pkg::POS_W'(i_idx);
    assign w_above = (w_idx > i_ctl.pos);
    assign w_at    = (w_idx == i_ctl.pos);

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_val = i_lower;
            end else if (w_at) begin
                n_val = i_ctl.val;
            end
        end else if (i_ctl.del) begin
            if (w_above || w_at) begin
                n_val = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_ctl.tap) begin
            r_tap <= w_at ? r_val : '0;
        end
    end

    assign o_val = r_val;
    assign o_tap = r_tap;

endmodule

// ===== hdl/ple_row.sv =====
module ple_row (
    input  logic                              i_clk,
    input  ple_pkg::t_cell_ctl                i_ctl,
    output logic signed [ple_pkg::DATA_W-1:0] o_read
);

    logic signed [ple_pkg::DATA_W-1:0] w_val [ple_pkg::DEPTH];
    logic signed [ple_pkg::DATA_W-1:0] w_tap [ple_pkg::DEPTH];

    for (genvar k = 0; k < ple_pkg::DEPTH; k++) begin : g_cell
        logic signed [ple_pkg::DATA_W-1:0] w_lower;
        logic signed [ple_pkg::DATA_W-1:0] w_upper;

        // end cells feed back on themselves; their shifted-in data is never read
        if (k == 0) begin : g_first
            assign w_lower = w_val[k];
        end else begin : g_mid_lo
            assign w_lower = w_val[k-1];
        end
        if (k == ple_pkg::DEPTH - 1) begin : g_last
            assign w_upper = w_val[k];
        end else begin : g_mid_hi
            assign w_upper = w_val[k+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (ple_pkg::IDX_W'(k)),
            .i_ctl   (i_ctl),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_val   (w_val[k]),
            .o_tap   (w_tap[k])
        );
    end

    // only the addressed cell holds a nonzero tap
    always_comb begin
        o_read = '0;
        for (int k = 0; k < ple_pkg::DEPTH; k++) begin
            o_read = o_read | w_tap[k];
        end
    end

endmodule

// ===== hdl/positional_list_engine_unit.sv =====
// Positional list engine: an ordered list of up to 32 signed 32-bit entries.
// Input channel (i_valid / o_stall): a transaction carries i_op (insert,
// delete, read, clear), i_position and i_value. Output channel (o_valid /
// i_stall): one result transaction per request with o_ok, o_read_value,
// o_count and o_empty_res.
// Each entry lives in one cell of a row. Insert shifts every cell above the
// position up, delete shifts the cell at the position and every cell above
// it down; a read taps the addressed cell and the taps are OR-combined in
// the cycle after. A result passes through the execute step, then the read
// combine into the output register. Only one request occupies the execute
// and combine steps at a time, so the next request is accepted only once
// the previous one has left both steps.
// The next request may be accepted while a finished result still waits in
// the output register; it then stops ahead of the output until i_stall drops.
// While i_stall is high the output payload holds.
// Reset (synchronous, i_rst_n low) empties the list and drops all valids;
// entry contents are left as they are and never read before being written.
module positional_list_engine_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_op,
    input  logic signed [ple_pkg::DATA_W-1:0] i_value,
    input  logic [ple_pkg::POS_W-1:0]         i_position,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ok,
    output logic signed [ple_pkg::DATA_W-1:0] o_read_value,
    output logic [ple_pkg::CNT_W-1:0]         o_count,
    output logic                              o_empty_res
);

    localparam logic [ple_pkg::CNT_W-1:0] FULL = ple_pkg::CNT_W'(ple_pkg::DEPTH);

    logic                              r_x_valid;
    logic [1:0]                        r_x_op;
    logic [ple_pkg::POS_W-1:0]         r_x_pos;
    logic signed [ple_pkg::DATA_W-1:0] r_x_val;
    logic                              r_r_valid;
    logic                              r_r_ok;
    logic [1:0]                        r_r_op;
    logic [ple_pkg::CNT_W-1:0]         r_count;
    logic [ple_pkg::CNT_W-1:0]         n_count;
    logic                              r_o_valid;
    logic                              r_o_ok;
    logic signed [ple_pkg::DATA_W-1:0] r_o_rd;
    logic [ple_pkg::CNT_W-1:0]         r_o_count;
    logic                              r_o_empty;

    logic                              w_accept;
    logic                              w_ok;
    logic                              w_advance;
    logic signed [ple_pkg::DATA_W-1:0] w_row_read;
    logic signed [ple_pkg::DATA_W-1:0] w_rd;
    ple_pkg::t_cell_ctl                w_ctl;

    assign o_stall   = r_x_valid | r_r_valid;
    assign w_accept  = i_valid & ~o_stall;
    assign w_advance = r_r_valid & (~r_o_valid | ~i_stall);

    always_comb begin
        w_ok    = 1'b0;
        n_count = r_count;
        unique case (r_x_op)
            ple_pkg::OP_INSERT: begin
                w_ok = (r_x_pos <= r_count) && (r_count < FULL);
                if (w_ok) n_count = r_count + 1'b1;
            end
            ple_pkg::OP_DELETE: begin
                w_ok = (r_x_pos < r_count);
                if (w_ok) n_count = r_count - 1'b1;
            end
            ple_pkg::OP_READ: begin
                w_ok = (r_x_pos < r_count);
            end
            ple_pkg::OP_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl.ins = r_x_valid && w_ok && (r_x_op == ple_pkg::OP_INSERT);
        w_ctl.del = r_x_valid && w_ok && (r_x_op == ple_pkg::OP_DELETE);
        w_ctl.tap = r_x_valid;
        w_ctl.pos = r_x_pos;
        w_ctl.val = r_x_val;
    end

    ple_row u_row (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_read (w_row_read)
    );

    always_comb begin
        if (r_r_op == ple_pkg::OP_READ) begin
            w_rd = r_r_ok ? w_row_read : ple_pkg::DATA_W'(1);
        end else begin
            w_rd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_x_valid <= w_accept;
            if (r_x_valid) begin
                r_count   <= n_count;
                r_r_valid <= 1'b1;
            end else if (w_advance) begin
                r_r_valid <= 1'b0;
            end
            if (w_advance) begin
                r_o_valid <= 1'b1;
            end else if (~i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x_op  <= i_op;
            r_x_pos <= i_position;
            r_x_val <= i_value;
        end
        if (r_x_valid) begin
            r_r_ok <= w_ok;
            r_r_op <= r_x_op;
        end
        if (w_advance) begin
            r_o_ok    <= r_r_ok;
            r_o_rd    <= w_rd;
            r_o_count <= r_count;
            r_o_empty <= (r_count == '0);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_ok         = r_o_ok;
    assign o_read_value = r_o_rd;
    assign o_count      = r_o_count;
    assign o_empty_res  = r_o_empty;

endmodule
